[rtl/sce_pkg.sv]
package sce_pkg;

	// op codes follow the instruction mode encoding; unused modes decode to OP_NOP
	typedef enum logic [4:0] {
		OP_MOVI,
		OP_MOV,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_AND,
		OP_XOR,
		OP_OR,
		OP_SHR,
		OP_SHL,
		OP_ROR,
		OP_ROL,
		OP_CMP,
		OP_NOT,
		OP_PUSH,
		OP_POP,
		OP_NOP,
		OP_HALT,
		OP_JMP,
		OP_JEQ,
		OP_JLT,
		OP_JGT
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_HALT  = 2'd3;

	localparam logic [15:0] SHIFT_MAX = 16'd15;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [4:0]  mode;
		logic [2:0]  dest_index;
		logic [2:0]  src_a_index;
		logic [2:0]  src_b_index;
		logic [15:0] immediate;
	} instr_t;

	typedef struct packed {
		logic [15:0] pc_value;
		logic [15:0] written_value;
		logic        write_done;
		logic [2:0]  written_index;
		logic        zero_flag;
		logic        less_flag;
		logic [5:0]  stack_level;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		op_t         op;
		logic        writes_reg;
		logic [2:0]  dest_index;
		logic        dest_ok;
		logic [2:0]  rd0_index;
		logic        rd0_ok;
		logic [2:0]  rd1_index;
		logic        rd1_ok;
		logic        shift_big;
		logic [15:0] immediate;
	} dec_item_t;

endpackage

[rtl/small_cpu_execute_unit.sv]
// Execute unit for a 16-bit machine with a small register file and a word stack.
// Instruction channel: instr_valid/instr_ready with one instruction per item.
// Result channel: result_valid/result_ready with one result item per instruction,
// in instruction order.
// The front decodes each item into a two-entry queue; the back reads operands from
// the register file RAMs and executes one item per cycle.
// An accepted item passes through the queue, the s1 register and the result register.
// Throughput: one item per cycle; operand RAM reads are launched as the item enters
// s1 and forwarded from the preceding write, the stack top is held in a register.
// When result_ready is low the result register holds, the back stops, and
// instr_ready drops once the queue is full; nothing is lost.
// Reset: registers read as zero, pc and flags clear, stack empty, halt clear.
// After halt every item returns the unchanged state with status halted.
module small_cpu_execute_unit #(
	parameter int REG_COUNT   = 8,
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             instr_valid,
	output logic             instr_ready,
	input  sce_pkg::instr_t  instr,
	output logic             result_valid,
	input  logic             result_ready,
	output sce_pkg::result_t result
);

	import sce_pkg::*;

	dec_item_t push_item;
	dec_item_t head;
	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;

	sce_front #(.REG_COUNT(REG_COUNT)) u_front (
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.instr       (instr),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	sce_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head)
	);

	sce_back #(.REG_COUNT(REG_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (!q_empty),
		.q_pop        (q_pop),
		.q_item       (head),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[rtl/sce_ram.sv]
module sce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/sce_front.sv]
module sce_front #(
	parameter int REG_COUNT = 8
) (
	input  logic               instr_valid,
	output logic               instr_ready,
	input  sce_pkg::instr_t    instr,
	input  logic               q_full,
	output logic               q_push,
	output sce_pkg::dec_item_t q_item
);

	import sce_pkg::*;

	op_t op;

	always_comb begin
		op = (instr.mode > 5'(OP_JGT)) ? OP_NOP : op_t'(instr.mode);

		q_item.op         = op;
		q_item.writes_reg = op inside {[OP_MOVI:OP_ROL], OP_NOT, OP_POP};
		q_item.dest_index = instr.dest_index;
		q_item.dest_ok    = int'(instr.dest_index) < REG_COUNT;
		// push reads its source through the first read port
		q_item.rd0_index  = (op == OP_PUSH) ? instr.dest_index : instr.src_a_index;
		q_item.rd0_ok     = int'(q_item.rd0_index) < REG_COUNT;
		q_item.rd1_index  = instr.src_b_index;
		q_item.rd1_ok     = int'(instr.src_b_index) < REG_COUNT;
		q_item.shift_big  = instr.immediate > SHIFT_MAX;
		q_item.immediate  = instr.immediate;
	end

	assign instr_ready = !q_full;
	assign q_push      = instr_valid && !q_full;

endmodule

[rtl/sce_fifo.sv]
module sce_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sce_pkg::dec_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output sce_pkg::dec_item_t head
);

	import sce_pkg::*;

	dec_item_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	function automatic logic [QUEUE_AW-1:0] ptr_next(input logic [QUEUE_AW-1:0] p);
		ptr_next = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = count_q == QUEUE_CW'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

[rtl/sce_back.sv]
module sce_back #(
	parameter int REG_COUNT   = 8,
	parameter int STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  sce_pkg::dec_item_t q_item,
	output logic               result_valid,
	input  logic               result_ready,
	output sce_pkg::result_t   result
);

	import sce_pkg::*;

	localparam int RAW = $clog2(REG_COUNT);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam logic [5:0] SP_EMPTY = 6'(STACK_DEPTH);

	dec_item_t            item_s1;
	logic                 valid_s1;
	logic                 exec_fire;
	logic                 load_s1;

	logic [RAW-1:0]       raddr0;
	logic [RAW-1:0]       raddr1;
	logic [RAW-1:0]       rf_waddr;
	logic                 rf_we;
	logic [15:0]          rf_wdata;
	logic [15:0]          rdata0;
	logic [15:0]          rdata1;
	logic [REG_COUNT-1:0] rf_valid_q;
	logic                 rvld0_q;
	logic                 rvld1_q;
	logic                 rhit0_q;
	logic                 rhit1_q;
	logic [15:0]          rfwd_q;

	logic                 st_we;
	logic [SAW-1:0]       st_waddr;
	logic [SAW-1:0]       st_raddr;
	logic [15:0]          st_rdata;
	logic                 st_hit_q;
	logic [15:0]          st_fwd_q;
	logic [5:0]           sp_d;
	logic [6:0]           sp_plus;
	logic [15:0]          second;

	logic [15:0]          pc_q;
	logic                 zf_q;
	logic                 lf_q;
	logic [5:0]           sp_q;
	logic [15:0]          tos_q;
	logic                 halted_q;

	logic [15:0]          pc_n;
	logic                 zf_n;
	logic                 lf_n;
	logic [5:0]           sp_n;
	logic [15:0]          tos_n;
	logic                 halted_n;
	logic [15:0]          res;
	logic                 wr;
	logic                 wr_eff;
	logic [1:0]           status;
	logic                 push_ok;
	logic [15:0]          a_val;
	logic [15:0]          b_val;
	logic [31:0]          prod;

	logic                 result_valid_q;
	result_t              result_q;

	assign exec_fire = valid_s1 && (!result_valid_q || result_ready);
	assign load_s1   = q_valid && (!valid_s1 || exec_fire);
	assign q_pop     = load_s1;

	// operand read is launched as the item enters s1 and re-issued while it waits
	assign raddr0 = load_s1 ? RAW'(q_item.rd0_index) : RAW'(item_s1.rd0_index);
	assign raddr1 = load_s1 ? RAW'(q_item.rd1_index) : RAW'(item_s1.rd1_index);

	sce_ram #(.WIDTH(16), .DEPTH(REG_COUNT), .AW(RAW)) u_rf0 (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (raddr0),
		.rdata (rdata0)
	);

	sce_ram #(.WIDTH(16), .DEPTH(REG_COUNT), .AW(RAW)) u_rf1 (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (raddr1),
		.rdata (rdata1)
	);

	// top of stack lives in tos_q, the RAM holds the entries below it
	assign sp_d     = exec_fire ? sp_n : sp_q;
	assign sp_plus  = {1'b0, sp_d} + 7'd1;
	assign st_raddr = (sp_plus < 7'(STACK_DEPTH)) ? SAW'(sp_plus) : '0;
	assign st_waddr = SAW'(sp_q);

	sce_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (tos_q),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	assign second = st_hit_q ? st_fwd_q : st_rdata;

	assign a_val = !item_s1.rd0_ok ? 16'd0 : rhit0_q ? rfwd_q : rvld0_q ? rdata0 : 16'd0;
	assign b_val = !item_s1.rd1_ok ? 16'd0 : rhit1_q ? rfwd_q : rvld1_q ? rdata1 : 16'd0;
	assign prod  = a_val * b_val;

	always_comb begin
		pc_n     = pc_q;
		zf_n     = zf_q;
		lf_n     = lf_q;
		sp_n     = sp_q;
		tos_n    = tos_q;
		halted_n = halted_q;
		res      = '0;
		wr       = 1'b0;
		status   = ST_OK;
		push_ok  = 1'b0;

		if (halted_q) begin
			status = ST_HALT;
		end else begin
			wr = item_s1.writes_reg;
			case (item_s1.op)
				OP_MOVI: res = item_s1.immediate;
				OP_MOV:  res = a_val;
				OP_ADD:  res = a_val + b_val;
				OP_SUB:  res = a_val - b_val;
				OP_MUL:  res = prod[15:0];
				OP_AND:  res = a_val & b_val;
				OP_XOR:  res = a_val ^ b_val;
				OP_OR:   res = a_val | b_val;
				OP_SHR:  res = item_s1.shift_big ? 16'd0 : a_val >> item_s1.immediate[3:0];
				OP_SHL:  res = item_s1.shift_big ? 16'd0 : a_val << item_s1.immediate[3:0];
				OP_ROR:  res = {a_val[0], a_val[15:1]};
				OP_ROL:  res = {a_val[14:0], a_val[15]};
				OP_NOT:  res = ~a_val;
				OP_CMP: begin
					zf_n = a_val == b_val;
					lf_n = a_val < b_val;
				end
				OP_PUSH: begin
					if (sp_q == '0) begin
						status = ST_FULL;
					end else begin
						push_ok = 1'b1;
						sp_n    = sp_q - 6'd1;
						tos_n   = a_val;
					end
				end
				OP_POP: begin
					if (sp_q >= SP_EMPTY) begin
						status = ST_EMPTY;
						wr     = 1'b0;
					end else begin
						res   = tos_q;
						sp_n  = sp_q + 6'd1;
						tos_n = second;
					end
				end
				OP_HALT: begin
					halted_n = 1'b1;
					status   = ST_HALT;
				end
				OP_JMP: pc_n = pc_q + item_s1.immediate;
				OP_JEQ: begin
					if (zf_q) begin
						pc_n = item_s1.immediate;
					end
				end
				OP_JLT: begin
					if (lf_q && !zf_q) begin
						pc_n = item_s1.immediate;
					end
				end
				OP_JGT: begin
					if (!lf_q && !zf_q) begin
						pc_n = item_s1.immediate;
					end
				end
				default: ;
			endcase
		end

		wr_eff = wr && item_s1.dest_ok;
	end

	assign rf_we    = exec_fire && wr_eff;
	assign rf_waddr = RAW'(item_s1.dest_index);
	assign rf_wdata = res;
	assign st_we    = exec_fire && push_ok && (sp_q < SP_EMPTY);

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= q_item;
		end
		rfwd_q   <= rf_wdata;
		st_fwd_q <= tos_q;
		if (exec_fire) begin
			tos_q                  <= tos_n;
			result_q.pc_value      <= pc_n;
			result_q.written_value <= wr_eff ? res : 16'd0;
			result_q.write_done    <= wr_eff;
			result_q.written_index <= wr_eff ? item_s1.dest_index : 3'd0;
			result_q.zero_flag     <= zf_n;
			result_q.less_flag     <= lf_n;
			result_q.stack_level   <= sp_n;
			result_q.status        <= status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			rf_valid_q     <= '0;
			rvld0_q        <= 1'b0;
			rvld1_q        <= 1'b0;
			rhit0_q        <= 1'b0;
			rhit1_q        <= 1'b0;
			st_hit_q       <= 1'b0;
			pc_q           <= '0;
			zf_q           <= 1'b0;
			lf_q           <= 1'b0;
			sp_q           <= SP_EMPTY;
			halted_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (exec_fire) begin
				valid_s1 <= 1'b0;
			end
			if (rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end
			rvld0_q  <= rf_valid_q[raddr0];
			rvld1_q  <= rf_valid_q[raddr1];
			rhit0_q  <= rf_we && (rf_waddr == raddr0);
			rhit1_q  <= rf_we && (rf_waddr == raddr1);
			st_hit_q <= st_we && (st_waddr == st_raddr);
			if (exec_fire) begin
				pc_q     <= pc_n;
				zf_q     <= zf_n;
				lf_q     <= lf_n;
				sp_q     <= sp_n;
				halted_q <= halted_n;
			end
			if (exec_fire) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assert property (@(posedge clk) disable iff (!arst_n) sp_q <= SP_EMPTY)
		else $error("stack pointer beyond empty level");
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |=> halted_q)
		else $error("halt bit cleared without reset");
	assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && halted_q |=> $stable(pc_q) && $stable(sp_q) && $stable(rf_valid_q))
		else $error("state changed while halted");
	assert property (@(posedge clk) disable iff (!arst_n) rf_we |-> !halted_q)
		else $error("register write while halted");
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status == ST_HALT |-> halted_q)
		else $error("halt status without halt bit");

endmodule

[tb/sce_checker.sv]
module sce_checker #(
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             instr_valid,
	input  logic             instr_ready,
	input  sce_pkg::instr_t  instr,
	input  logic             result_valid,
	input  logic             result_ready,
	input  sce_pkg::result_t result,
	output int               mismatches,
	output int               pending,
	output int               results_seen,
	output int               full_hits,
	output int               empty_hits
);

	import sce_pkg::*;

	logic [15:0] regs [8];
	logic [15:0] stack_mem [STACK_DEPTH];
	logic [15:0] pc;
	logic [5:0]  sp;
	logic        zf;
	logic        lf;
	logic        halted;
	result_t     expected_results [$];

	initial begin
		mismatches   = 0;
		pending      = 0;
		results_seen = 0;
		full_hits    = 0;
		empty_hits   = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic execute_instr(input instr_t x, output result_t r);
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] val;
		logic        wr;
		logic [1:0]  st;
		op_t         op;
		a   = regs[x.src_a_index];
		b   = regs[x.src_b_index];
		val = '0;
		wr  = 1'b0;
		st  = ST_OK;
		op  = op_t'(x.mode);
		if (halted) begin
			st = ST_HALT;
		end else begin
			case (op)
				OP_MOVI: begin val = x.immediate; wr = 1'b1; end
				OP_MOV:  begin val = a; wr = 1'b1; end
				OP_ADD:  begin val = a + b; wr = 1'b1; end
				OP_SUB:  begin val = a - b; wr = 1'b1; end
				OP_MUL:  begin val = a * b; wr = 1'b1; end
				OP_AND:  begin val = a & b; wr = 1'b1; end
				OP_XOR:  begin val = a ^ b; wr = 1'b1; end
				OP_OR:   begin val = a | b; wr = 1'b1; end
				OP_SHR: begin
					val = (x.immediate > SHIFT_MAX) ? 16'd0 : a >> x.immediate;
					wr  = 1'b1;
				end
				OP_SHL: begin
					val = (x.immediate > SHIFT_MAX) ? 16'd0 : a << x.immediate;
					wr  = 1'b1;
				end
				OP_ROR:  begin val = {a[0], a[15:1]}; wr = 1'b1; end
				OP_ROL:  begin val = {a[14:0], a[15]}; wr = 1'b1; end
				OP_CMP:  begin zf = (a == b); lf = (a < b); end
				OP_NOT:  begin val = ~a; wr = 1'b1; end
				OP_PUSH: begin
					if (sp == 0) begin
						st = ST_FULL;
					end else begin
						sp            = sp - 1'b1;
						stack_mem[sp] = regs[x.dest_index];
					end
				end
				OP_POP: begin
					if (sp >= STACK_DEPTH) begin
						st = ST_EMPTY;
					end else begin
						val = stack_mem[sp];
						wr  = 1'b1;
						sp  = sp + 1'b1;
					end
				end
				OP_HALT: begin halted = 1'b1; st = ST_HALT; end
				OP_JMP:  pc = pc + x.immediate;
				OP_JEQ:  if (zf) pc = x.immediate;
				OP_JLT:  if (lf && !zf) pc = x.immediate;
				OP_JGT:  if (!lf && !zf) pc = x.immediate;
				default: ;
			endcase
		end
		if (wr)
			regs[x.dest_index] = val;
		r.pc_value      = pc;
		r.written_value = wr ? val : 16'd0;
		r.write_done    = wr;
		r.written_index = wr ? x.dest_index : 3'd0;
		r.zero_flag     = zf;
		r.less_flag     = lf;
		r.stack_level   = sp;
		r.status        = st;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (regs[i])
				regs[i] = '0;
			foreach (stack_mem[i])
				stack_mem[i] = '0;
			pc     = '0;
			sp     = 6'(STACK_DEPTH);
			zf     = 1'b0;
			lf     = 1'b0;
			halted = 1'b0;
			expected_results.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no instruction outstanding");
				end else begin
					want = expected_results.pop_front();
					compare_field("pc_value", result.pc_value, want.pc_value);
					compare_field("written_value", result.written_value, want.written_value);
					compare_field("write_done", result.write_done, want.write_done);
					compare_field("written_index", result.written_index, want.written_index);
					compare_field("zero_flag", result.zero_flag, want.zero_flag);
					compare_field("less_flag", result.less_flag, want.less_flag);
					compare_field("stack_level", result.stack_level, want.stack_level);
					compare_field("status", result.status, want.status);
					if (want.status == ST_FULL)
						full_hits++;
					if (want.status == ST_EMPTY)
						empty_hits++;
				end
				results_seen++;
			end
			if (instr_valid && instr_ready) begin
				execute_instr(instr, want);
				expected_results.push_back(want);
			end
		end
		pending = expected_results.size();
	end

endmodule

[tb/tb_small_cpu_execute_unit.sv]
module tb_small_cpu_execute_unit;
	import sce_pkg::*;

	localparam logic [4:0] MODE_UNUSED_TOP = 5'd31;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    instr_valid  = 1'b0;
	logic    instr_ready;
	instr_t  instr        = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	int mismatches;
	int pending;
	int results_seen;
	int full_hits;
	int empty_hits;
	int items_sent    = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_cycles   = 0;

	small_cpu_execute_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_ready  (instr_ready),
		.instr        (instr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	sce_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_ready  (instr_ready),
		.instr        (instr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.full_hits    (full_hits),
		.empty_hits   (empty_hits)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("small_cpu_execute_unit test failed");
		$finish;
	end

	// receiver: random stalls, or a counted hold-off when requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				hold_cycles--;
			end else begin
				result_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic instr_t mk(input logic [4:0] m, input logic [2:0] d,
			input logic [2:0] a, input logic [2:0] b, input logic [15:0] imm);
		instr_t x;
		x.mode        = m;
		x.dest_index  = d;
		x.src_a_index = a;
		x.src_b_index = b;
		x.immediate   = imm;
		return x;
	endfunction

	function automatic instr_t random_instr(input logic [4:0] m);
		logic [15:0] imm;
		logic [2:0]  a;
		logic [2:0]  b;
		imm = ($urandom_range(2) == 0) ? 16'($urandom_range(20)) : 16'($urandom);
		a   = 3'($urandom_range(7));
		b   = ($urandom_range(2) == 0) ? a : 3'($urandom_range(7));
		return mk(m, 3'($urandom_range(7)), a, b, imm);
	endfunction

	task automatic send_item(input instr_t x);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			instr_valid <= 1'b0;
			@(negedge clk);
		end
		instr       <= x;
		instr_valid <= 1'b1;
		do @(posedge clk); while (!instr_ready);
		items_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		instr_valid <= 1'b0;
		wait (pending == 0);
	endtask

	task automatic run_random(input int n);
		int   count;
		int   len;
		logic [4:0] m;
		count = 0;
		while (count < n) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					send_item(random_instr(5'($urandom_range(OP_NOT))));
					count++;
				end
				4, 5: begin
					send_item(random_instr(OP_CMP));
					send_item(random_instr(5'($urandom_range(OP_JMP, OP_JGT))));
					count += 2;
				end
				6, 7: begin
					len = $urandom_range(1, 36);
					m   = ($urandom_range(1) == 0) ? OP_PUSH : OP_POP;
					repeat (len)
						send_item(random_instr(m));
					count += len;
				end
				8: begin
					m = 5'($urandom_range(31));
					if (m == OP_HALT)
						m = OP_NOP;
					send_item(random_instr(m));
					count++;
				end
				default: begin
					send_item(mk(OP_MOVI, 3'($urandom_range(7)), 3'($urandom_range(7)),
						3'($urandom_range(7)), 16'($urandom)));
					count++;
				end
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(mk(OP_POP,  3'd1, 3'd0, 3'd0, 16'h0000));
		send_item(mk(OP_MOVI, 3'd1, 3'd0, 3'd0, 16'hFFFF));
		send_item(mk(OP_MOVI, 3'd2, 3'd0, 3'd0, 16'h8001));
		send_item(mk(OP_ADD,  3'd3, 3'd1, 3'd2, 16'h0000));
		send_item(mk(OP_SUB,  3'd4, 3'd0, 3'd1, 16'h0000));
		send_item(mk(OP_MUL,  3'd5, 3'd1, 3'd2, 16'h0000));
		send_item(mk(OP_AND,  3'd6, 3'd1, 3'd2, 16'h0000));
		send_item(mk(OP_XOR,  3'd7, 3'd1, 3'd2, 16'h0000));
		send_item(mk(OP_OR,   3'd0, 3'd2, 3'd4, 16'h0000));
		send_item(mk(OP_SHR,  3'd3, 3'd1, 3'd0, 16'd15));
		send_item(mk(OP_SHR,  3'd3, 3'd1, 3'd0, 16'd16));
		send_item(mk(OP_SHL,  3'd4, 3'd1, 3'd0, 16'hFFFF));
		send_item(mk(OP_SHL,  3'd4, 3'd2, 3'd0, 16'd0));
		send_item(mk(OP_ROR,  3'd5, 3'd2, 3'd0, 16'h0000));
		send_item(mk(OP_ROL,  3'd5, 3'd2, 3'd0, 16'h0000));
		send_item(mk(OP_NOT,  3'd6, 3'd1, 3'd0, 16'h0000));
		send_item(mk(OP_CMP,  3'd0, 3'd1, 3'd1, 16'h0000));
		send_item(mk(OP_JEQ,  3'd0, 3'd0, 3'd0, 16'hFFFF));
		send_item(mk(OP_JMP,  3'd0, 3'd0, 3'd0, 16'h0002));
		send_item(mk(OP_CMP,  3'd0, 3'd2, 3'd1, 16'h0000));
		send_item(mk(OP_JLT,  3'd0, 3'd0, 3'd0, 16'h1234));
		send_item(mk(OP_JGT,  3'd0, 3'd0, 3'd0, 16'h5555));
		send_item(mk(OP_CMP,  3'd0, 3'd1, 3'd2, 16'h0000));
		send_item(mk(OP_JGT,  3'd0, 3'd0, 3'd0, 16'hABCD));
		send_item(mk(OP_PUSH, 3'd1, 3'd0, 3'd0, 16'h0000));
		send_item(mk(OP_POP,  3'd7, 3'd0, 3'd0, 16'h0000));
		send_item(mk(OP_NOP,  3'd7, 3'd7, 3'd7, 16'hFFFF));
		send_item(mk(MODE_UNUSED_TOP, 3'd7, 3'd7, 3'd7, 16'hFFFF));
		wait_drain();

		run_random(260);

		// long receiver hold-off while pushes keep coming: fills the block and the stack
		hold_cycles = 80;
		repeat (40)
			send_item(random_instr(OP_PUSH));
		wait_drain();

		send_idle_pct = 78;
		stall_pct     = 0;
		run_random(170);
		send_idle_pct = 0;
		stall_pct     = 78;
		run_random(170);
		send_idle_pct = 22;
		stall_pct     = 22;
		run_random(250);
		wait_drain();

		// halt is sticky until reset, so it closes the run
		send_item(mk(OP_HALT, 3'd0, 3'd0, 3'd0, 16'h0000));
		repeat (20)
			send_item(random_instr(5'($urandom_range(31))));
		wait_drain();
		repeat (8) @(posedge clk);

		$display("covered %0d instructions with all operations and idle patterns, %0d results",
			items_sent, results_seen);
		$display("stack full seen %0d times, stack empty %0d times, halt held to the end",
			full_hits, empty_hits);
		if (mismatches == 0 && pending == 0)
			$display("small_cpu_execute_unit test passed");
		else
			$display("small_cpu_execute_unit test failed");
		$finish;
	end

endmodule

[sim.f]
rtl/sce_pkg.sv
rtl/sce_ram.sv
rtl/sce_front.sv
rtl/sce_fifo.sv
rtl/sce_back.sv
rtl/small_cpu_execute_unit.sv
tb/sce_checker.sv
tb/tb_small_cpu_execute_unit.sv
